>>> rtl/rotozoom_address_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Rotozoom address generator assertion macros
// Property wrappers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ROTOZOOM_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define ROTOZOOM_ADDRESS_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RZA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RZA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rza_pkg.sv
// ----------------------------------------------------------------------------
// rza_pkg
// Shared constants, register codes and inter-module structs of the
// rotozoom address generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rza_pkg;

    localparam int MAX_DIM       = 1024;
    localparam int DIM_W         = 10;
    localparam int CFG_W         = 11;
    localparam int ACC_W         = 32;
    localparam int FRAC_W        = 16;
    localparam int COORD_W       = ACC_W - FRAC_W;
    localparam int ADDR_W        = 20;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int SETTLE_CYCLES = 3;
    localparam int SETTLE_W      = 2;
    localparam int TDATA_IN_W    = 8;
    localparam int TDATA_OUT_W   = 72;
    localparam int TUSER_OUT_W   = 3;

    typedef enum logic [2:0] {
        REG_COS_STEP,
        REG_SIN_STEP,
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_SRC_PITCH,
        REG_DST_WIDTH,
        REG_DST_HEIGHT,
        REG_TRANSPARENT
    } reg_idx_t;

    // walker controls from the setup unit to the front end
    typedef struct packed {
        logic [ACC_W-1:0] cos_step;
        logic [ACC_W-1:0] sin_step;
        logic [ACC_W-1:0] start_x;
        logic [ACC_W-1:0] start_y;
        logic [DIM_W-1:0] w_last;
        logic [DIM_W-1:0] h_last;
        logic             settled;
    } frame_ctl_t;

    // source image settings used by the back end
    typedef struct packed {
        logic [CFG_W-1:0] src_width;
        logic [CFG_W-1:0] src_height;
        logic [CFG_W-1:0] src_pitch;
        logic             transparent;
    } pix_cfg_t;

    // one walked pixel between front and back end
    typedef struct packed {
        logic [DIM_W-1:0]          dst_x;
        logic [DIM_W-1:0]          dst_y;
        logic signed [COORD_W-1:0] src_x;
        logic signed [COORD_W-1:0] src_y;
        logic                      last;
    } pix_raw_t;

endpackage

>>> rtl/rza_setup.sv
// ----------------------------------------------------------------------------
// rza_setup
// Configuration registers on the APB port and the registered frame start
// point computation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rza_setup (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rza_pkg::PADDR_W-1:0] paddr,
    input  logic [rza_pkg::PDATA_W-1:0] pwdata,
    output logic [rza_pkg::PDATA_W-1:0] prdata,
    output logic                       pready,
    output rza_pkg::frame_ctl_t        fctl,
    output rza_pkg::pix_cfg_t          pcfg
);
    import rza_pkg::*;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] r;
        if (d == '0)
        begin
            r = CFG_W'(1);
        end
        else if (d > CFG_W'(MAX_DIM))
        begin
            r = CFG_W'(MAX_DIM);
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    logic [ACC_W-1:0]    cos_step_reg;
    logic [ACC_W-1:0]    sin_step_reg;
    logic [CFG_W-1:0]    src_width_reg;
    logic [CFG_W-1:0]    src_height_reg;
    logic [CFG_W-1:0]    src_pitch_reg;
    logic [CFG_W-1:0]    dst_width_reg;
    logic [CFG_W-1:0]    dst_height_reg;
    logic                transparent_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    logic [ACC_W-1:0]    sum_reg;
    logic [ACC_W-1:0]    diff_reg;
    logic [DIM_W-1:0]    hw_reg;
    logic [DIM_W-1:0]    hh_reg;
    logic [DIM_W-1:0]    w_last_reg;
    logic [DIM_W-1:0]    h_last_reg;
    logic [ACC_W-1:0]    start_x_reg;
    logic [ACC_W-1:0]    start_y_reg;

    logic                wr_en;
    reg_idx_t            idx;
    logic [CFG_W-1:0]    eff_w;
    logic [CFG_W-1:0]    eff_h;
    logic [ACC_W-1:0]    prod_x;
    logic [ACC_W-1:0]    prod_y;
    logic [ACC_W-1:0]    base_x;
    logic [ACC_W-1:0]    base_y;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_step_reg    <= 32'h0001_0000;
            sin_step_reg    <= '0;
            src_width_reg   <= CFG_W'(320);
            src_height_reg  <= CFG_W'(240);
            src_pitch_reg   <= CFG_W'(320);
            dst_width_reg   <= CFG_W'(320);
            dst_height_reg  <= CFG_W'(240);
            transparent_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_COS_STEP:    cos_step_reg    <= pwdata;
                REG_SIN_STEP:    sin_step_reg    <= pwdata;
                REG_SRC_WIDTH:   src_width_reg   <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT:  src_height_reg  <= pwdata[CFG_W-1:0];
                REG_SRC_PITCH:   src_pitch_reg   <= pwdata[CFG_W-1:0];
                REG_DST_WIDTH:   dst_width_reg   <= pwdata[CFG_W-1:0];
                REG_DST_HEIGHT:  dst_height_reg  <= pwdata[CFG_W-1:0];
                REG_TRANSPARENT: transparent_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_COS_STEP:    prdata = cos_step_reg;
            REG_SIN_STEP:    prdata = sin_step_reg;
            REG_SRC_WIDTH:   prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT:  prdata = PDATA_W'(src_height_reg);
            REG_SRC_PITCH:   prdata = PDATA_W'(src_pitch_reg);
            REG_DST_WIDTH:   prdata = PDATA_W'(dst_width_reg);
            REG_DST_HEIGHT:  prdata = PDATA_W'(dst_height_reg);
            REG_TRANSPARENT: prdata = PDATA_W'(transparent_reg);
            default:         prdata = '0;
        endcase
    end

    // hold the walker off until the start point pipeline has caught up
    always_comb
    begin
        if (wr_en)
        begin
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    assign eff_w = eff_dim(dst_width_reg);
    assign eff_h = eff_dim(dst_height_reg);

    // first stage: step sums and effective dimensions
    always_ff @(posedge clk)
    begin
        sum_reg    <= cos_step_reg + sin_step_reg;
        diff_reg   <= cos_step_reg - sin_step_reg;
        hw_reg     <= eff_w[CFG_W-1:1];
        hh_reg     <= eff_h[CFG_W-1:1];
        w_last_reg <= DIM_W'(eff_w - CFG_W'(1));
        h_last_reg <= DIM_W'(eff_h - CFG_W'(1));
    end

    assign base_x = ACC_W'({src_width_reg, 15'b0});
    assign base_y = ACC_W'({src_height_reg, 15'b0});
    assign prod_x = ACC_W'(hw_reg) * sum_reg;
    assign prod_y = ACC_W'(hh_reg) * diff_reg;

    // second stage: start point, wraps mod 2^32
    always_ff @(posedge clk)
    begin
        start_x_reg <= base_x - prod_x;
        start_y_reg <= base_y - prod_y;
    end

    assign fctl.cos_step = cos_step_reg;
    assign fctl.sin_step = sin_step_reg;
    assign fctl.start_x  = start_x_reg;
    assign fctl.start_y  = start_y_reg;
    assign fctl.w_last   = w_last_reg;
    assign fctl.h_last   = h_last_reg;
    assign fctl.settled  = (settle_reg == '0);

    assign pcfg.src_width   = src_width_reg;
    assign pcfg.src_height  = src_height_reg;
    assign pcfg.src_pitch   = src_pitch_reg;
    assign pcfg.transparent = transparent_reg;

endmodule

>>> rtl/rza_front.sv
// ----------------------------------------------------------------------------
// rza_front
// Raster walker: takes one tick per target pixel, steps the 16.16
// accumulators and the counters, and pushes the raw pixel into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rza_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 frame_start,
    input  rza_pkg::frame_ctl_t  fctl,
    input  logic                 q_full,
    output logic                 q_push,
    output rza_pkg::pix_raw_t    q_data
);
    import rza_pkg::*;

    logic [ACC_W-1:0] row_x_acc_reg;
    logic [ACC_W-1:0] row_y_acc_reg;
    logic [ACC_W-1:0] col_x_acc_reg;
    logic [ACC_W-1:0] col_y_acc_reg;
    logic [DIM_W-1:0] col_count_reg;
    logic [DIM_W-1:0] row_count_reg;
    logic [ACC_W-1:0] row_x_acc_next;
    logic [ACC_W-1:0] row_y_acc_next;
    logic [ACC_W-1:0] col_x_acc_next;
    logic [ACC_W-1:0] col_y_acc_next;
    logic [DIM_W-1:0] col_count_next;
    logic [DIM_W-1:0] row_count_next;

    logic [ACC_W-1:0] cur_rx;
    logic [ACC_W-1:0] cur_ry;
    logic [ACC_W-1:0] cur_cx;
    logic [ACC_W-1:0] cur_cy;
    logic [DIM_W-1:0] cur_cc;
    logic [DIM_W-1:0] cur_rc;
    logic             end_row;
    logic             end_frame;
    logic             accept;

    assign in_ready = fctl.settled && !q_full;
    assign accept   = in_valid && in_ready;

    // a start tick replaces the current position with the frame start point
    always_comb
    begin
        if (frame_start)
        begin
            cur_rx = fctl.start_x;
            cur_ry = fctl.start_y;
            cur_cx = fctl.start_x;
            cur_cy = fctl.start_y;
            cur_cc = '0;
            cur_rc = '0;
        end
        else
        begin
            cur_rx = row_x_acc_reg;
            cur_ry = row_y_acc_reg;
            cur_cx = col_x_acc_reg;
            cur_cy = col_y_acc_reg;
            cur_cc = col_count_reg;
            cur_rc = row_count_reg;
        end
    end

    assign end_row   = (cur_cc >= fctl.w_last);
    assign end_frame = end_row && (cur_rc >= fctl.h_last);

    assign q_push       = accept;
    assign q_data.dst_x = cur_cc;
    assign q_data.dst_y = cur_rc;
    assign q_data.src_x = cur_cx[ACC_W-1:FRAC_W];
    assign q_data.src_y = cur_cy[ACC_W-1:FRAC_W];
    assign q_data.last  = end_frame;

    always_comb
    begin
        row_x_acc_next = row_x_acc_reg;
        row_y_acc_next = row_y_acc_reg;
        col_x_acc_next = col_x_acc_reg;
        col_y_acc_next = col_y_acc_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (end_frame)
            begin
                row_x_acc_next = fctl.start_x;
                row_y_acc_next = fctl.start_y;
                col_x_acc_next = fctl.start_x;
                col_y_acc_next = fctl.start_y;
                col_count_next = '0;
                row_count_next = '0;
            end
            else if (end_row)
            begin
                row_x_acc_next = cur_rx + fctl.sin_step;
                row_y_acc_next = cur_ry + fctl.cos_step;
                col_x_acc_next = cur_rx + fctl.sin_step;
                col_y_acc_next = cur_ry + fctl.cos_step;
                col_count_next = '0;
                row_count_next = cur_rc + DIM_W'(1);
            end
            else
            begin
                row_x_acc_next = cur_rx;
                row_y_acc_next = cur_ry;
                col_x_acc_next = cur_cx + fctl.cos_step;
                col_y_acc_next = cur_cy - fctl.sin_step;
                col_count_next = cur_cc + DIM_W'(1);
                row_count_next = cur_rc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_acc_reg <= '0;
            row_y_acc_reg <= '0;
            col_x_acc_reg <= '0;
            col_y_acc_reg <= '0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            row_x_acc_reg <= row_x_acc_next;
            row_y_acc_reg <= row_y_acc_next;
            col_x_acc_reg <= col_x_acc_next;
            col_y_acc_reg <= col_y_acc_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

>>> rtl/rza_queue.sv
// ----------------------------------------------------------------------------
// rza_queue
// Short FIFO between the walker and the address stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rza_queue #(
    parameter int DEPTH = rza_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rza_pkg::pix_raw_t  push_data,
    input  logic               pop,
    output rza_pkg::pix_raw_t  head,
    output logic               full,
    output logic               empty
);
    import rza_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_raw_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/rza_back.sv
// ----------------------------------------------------------------------------
// rza_back
// Address stage: bounds check, source address and write flags, with the
// output register of the master side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rza_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rza_pkg::pix_cfg_t                  pcfg,
    input  rza_pkg::pix_raw_t                  head,
    input  logic                               q_empty,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rza_pkg::DIM_W-1:0]          dst_x,
    output logic [rza_pkg::DIM_W-1:0]          dst_y,
    output logic signed [rza_pkg::COORD_W-1:0] src_x,
    output logic signed [rza_pkg::COORD_W-1:0] src_y,
    output logic [rza_pkg::ADDR_W-1:0]         src_addr,
    output logic                               in_bounds,
    output logic                               do_write,
    output logic                               fill_zero,
    output logic                               last_pixel
);
    import rza_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic [DIM_W-1:0]          dst_x_reg;
    logic [DIM_W-1:0]          dst_y_reg;
    logic signed [COORD_W-1:0] src_x_reg;
    logic signed [COORD_W-1:0] src_y_reg;
    logic [ADDR_W-1:0]         src_addr_reg;
    logic                      in_bounds_reg;
    logic                      do_write_reg;
    logic                      fill_zero_reg;
    logic                      last_reg;

    logic                      inb;
    logic                      wr;
    logic [2*CFG_W-1:0]        row_off;
    logic [2*CFG_W-1:0]        addr_sum;

    assign q_pop = !q_empty && (!valid_reg || out_ready);

    assign inb = !head.src_x[COORD_W-1] && !head.src_y[COORD_W-1]
              && (head.src_x < COORD_W'(pcfg.src_width))
              && (head.src_y < COORD_W'(pcfg.src_height));
    assign wr  = inb || !pcfg.transparent;

    // in bounds, both coordinates are below 2^11, so the low bits suffice
    assign row_off  = head.src_y[CFG_W-1:0] * pcfg.src_pitch;
    assign addr_sum = row_off + (2*CFG_W)'(head.src_x[CFG_W-1:0]);

    always_comb
    begin
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dst_x_reg     <= head.dst_x;
            dst_y_reg     <= head.dst_y;
            src_x_reg     <= head.src_x;
            src_y_reg     <= head.src_y;
            src_addr_reg  <= inb ? addr_sum[ADDR_W-1:0] : '0;
            in_bounds_reg <= inb;
            do_write_reg  <= wr;
            fill_zero_reg <= wr && !inb;
            last_reg      <= head.last;
        end
    end

    assign out_valid  = valid_reg;
    assign dst_x      = dst_x_reg;
    assign dst_y      = dst_y_reg;
    assign src_x      = src_x_reg;
    assign src_y      = src_y_reg;
    assign src_addr   = src_addr_reg;
    assign in_bounds  = in_bounds_reg;
    assign do_write   = do_write_reg;
    assign fill_zero  = fill_zero_reg;
    assign last_pixel = last_reg;

endmodule

>>> rtl/rotozoom_address_generator_top.sv
// ----------------------------------------------------------------------------
// rotozoom_address_generator_top
// 16.16 fixed-point rotozoom address generator: one target pixel per tick.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+-----------------------------------------------------
//  s_*       | in        | tick; s_tdata[0] frame_start
//  m_*       | out       | pixel address; tdata, tuser, tlast (last_pixel)
//  APB       | in/out    | 8 registers at byte address 4*i, 32-bit data
//
//  One pixel per clock sustained while s_tready is high; the walker
//  accumulators step with one add per cycle, and the address stage holds one
//  11x11 multiply. A tick is registered in the queue and then in the output
//  register before it shows on m_tvalid. After reset and after every register
//  write, s_tready stays low while the two-stage start point pipeline settles.
//  A 4-entry queue lets the walker keep taking ticks while m_tready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotozoom_address_generator_top #(
    parameter int QUEUE_DEPTH = rza_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rza_pkg::TDATA_IN_W-1:0]    s_tdata,  // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] dst_x, [19:10] dst_y, [35:20] src_x, [51:36] src_y, [71:52] src_addr
    output logic [rza_pkg::TDATA_OUT_W-1:0]   m_tdata,
    // [0] in_bounds, [1] do_write, [2] fill_zero
    output logic [rza_pkg::TUSER_OUT_W-1:0]   m_tuser,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rza_pkg::PADDR_W-1:0]       paddr,
    input  logic [rza_pkg::PDATA_W-1:0]       pwdata,
    output logic [rza_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import rza_pkg::*;

    frame_ctl_t                fctl;
    pix_cfg_t                  pcfg;
    pix_raw_t                  q_in;
    pix_raw_t                  q_head;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;

    logic [DIM_W-1:0]          dst_x;
    logic [DIM_W-1:0]          dst_y;
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic [ADDR_W-1:0]         src_addr;
    logic                      in_bounds;
    logic                      do_write;
    logic                      fill_zero;

    rza_setup u_setup (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .fctl    (fctl),
        .pcfg    (pcfg)
    );

    rza_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .frame_start (s_tdata[0]),
        .fctl        (fctl),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    rza_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rza_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pcfg       (pcfg),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .dst_x      (dst_x),
        .dst_y      (dst_y),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_addr   (src_addr),
        .in_bounds  (in_bounds),
        .do_write   (do_write),
        .fill_zero  (fill_zero),
        .last_pixel (m_tlast)
    );

    assign m_tdata = {src_addr, src_y, src_x, dst_y, dst_x};
    assign m_tuser = {fill_zero, do_write, in_bounds};

endmodule

>>> rtl/rza_checker.sv
// ----------------------------------------------------------------------------
// rza_checker
// Port-level checks of the rotozoom address generator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rotozoom_address_generator_top_assert.svh"

module rza_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rza_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic [rza_pkg::TUSER_OUT_W-1:0] m_tuser,
    input  logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite
);
    import rza_pkg::*;

    // a stalled result holds
    `RZA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // zero fill only on a written, out-of-bounds pixel
    `RZA_ASSERT_IMP(a_fill_flags, m_tvalid && m_tuser[2], m_tuser[1] && !m_tuser[0], "fill_zero without do_write or with in_bounds")

    // out-of-bounds pixels carry address zero
    `RZA_ASSERT_IMP(a_oob_addr, m_tvalid && !m_tuser[0], m_tdata[71:52] == '0, "nonzero address out of bounds")

    // in bounds means non-negative source coordinates
    `RZA_ASSERT_IMP(a_inb_sign, m_tvalid && m_tuser[0], !m_tdata[35] && !m_tdata[51], "negative coordinate in bounds")

    // a register write stalls the input while the start point settles
    `RZA_ASSERT_NXT(a_cfg_stall, psel && penable && pwrite, !s_tready, "tick accepted right after a register write")

endmodule

bind rotozoom_address_generator_top rza_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite)
);
